FILE: rtl/core/spc_pkg.sv
// Package for the sphere pair collision time pipeline.
// Holds field widths and fixed-point constants shared by the core modules.
// No dependencies.
package spc_pkg;

    localparam int FIELD_BITS  = 63;   // packed three-axis vector
    localparam int RADIUS_BITS = 21;   // unsigned Q11.10 radius
    localparam int TIME_BITS   = 21;   // unsigned Q11.10 time
    localparam int FRAC_BITS   = 10;   // fractional bits of every quantity
    localparam int SUM_BITS    = RADIUS_BITS + 1;
    localparam int S_DATA_BITS = 320;  // 315 payload bits padded to bytes
    localparam int M_DATA_BITS = 24;   // 22 payload bits padded to bytes

endpackage

FILE: rtl/core/spc_wmul.sv
// Two-stage unsigned W x W multiplier built from four half-width products.
// Depends on nothing else.
module spc_wmul #(
    parameter int W = 44
) (
    input  logic             clk,
    input  logic             en,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [2*W-1:0]   p
);

    localparam int LO = W / 2;
    localparam int HI = W - LO;

    logic [2*LO-1:0]    ll_reg;
    logic [LO+HI-1:0]   lh_reg;
    logic [LO+HI-1:0]   hl_reg;
    logic [2*HI-1:0]    hh_reg;
    logic [2*W-1:0]     p_reg;
    logic [2*W-1:0]     p_next;

    // Partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[LO-1:0] * b[LO-1:0];
            lh_reg <= a[LO-1:0] * b[W-1:LO];
            hl_reg <= a[W-1:LO] * b[LO-1:0];
            hh_reg <= a[W-1:LO] * b[W-1:LO];
        end
    end

    assign p_next = (2*W)'(ll_reg)
                  + ((2*W)'(lh_reg) << LO)
                  + ((2*W)'(hl_reg) << LO)
                  + ((2*W)'(hh_reg) << (2*LO));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/spc_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband vector alongside; no package dependency.
module spc_sqrt #(
    parameter int RW  = 110,
    parameter int SBW = 178
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RW-1:0]     rad,
    input  logic [SBW-1:0]    sb_in,
    output logic              out_valid,
    output logic [RW/2-1:0]   root,
    output logic [SBW-1:0]    sb_out
);

    localparam int RB = RW / 2;

    logic              valid_reg [0:RB-1];
    logic [RB+1:0]     rem_reg   [0:RB-1];
    logic [RB-1:0]     root_reg  [0:RB-1];
    logic [RW-1:0]     rad_reg   [0:RB-1];
    logic [SBW-1:0]    sb_reg    [0:RB-1];

    logic              valid_st  [0:RB];
    logic [RB+1:0]     rem_st    [0:RB];
    logic [RB-1:0]     root_st   [0:RB];
    logic [RW-1:0]     rad_st    [0:RB];
    logic [SBW-1:0]    sb_st     [0:RB];

    assign valid_st[0] = in_valid;
    assign rem_st[0]   = '0;
    assign root_st[0]  = '0;
    assign rad_st[0]   = rad;
    assign sb_st[0]    = sb_in;

    for (genvar j = 0; j < RB; j++)
    begin : g_stage
        logic [RB+1:0] cur;
        logic [RB+1:0] trial;
        logic          ge;

        // Bring down the next two radicand bits and try a one digit
        assign cur   = {rem_st[j][RB-1:0], rad_st[j][RW-1 -: 2]};
        assign trial = {root_st[j], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_st[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? (cur - trial) : cur;
                root_reg[j] <= {root_st[j][RB-2:0], ge};
                rad_reg[j]  <= rad_st[j] << 2;
                sb_reg[j]   <= sb_st[j];
            end
        end

        assign valid_st[j+1] = valid_reg[j];
        assign rem_st[j+1]   = rem_reg[j];
        assign root_st[j+1]  = root_reg[j];
        assign rad_st[j+1]   = rad_reg[j];
        assign sb_st[j+1]    = sb_reg[j];
    end

    assign out_valid = valid_st[RB];
    assign root      = root_st[RB];
    assign sb_out    = sb_st[RB];

endmodule

FILE: rtl/core/spc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on spc_pkg for the quotient width.
module spc_div #(
    parameter int NW = 56,
    parameter int DW = 44
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         in_hit,
    input  logic [NW-1:0]                num,
    input  logic [DW-1:0]                den,
    output logic                         out_valid,
    output logic                         out_hit,
    output logic [spc_pkg::TIME_BITS-1:0] quo
);

    localparam int TB = spc_pkg::TIME_BITS;
    localparam int CW = (NW > DW + TB) ? NW : DW + TB;

    logic              valid_reg [0:TB-1];
    logic              hit_reg   [0:TB-1];
    logic [NW-1:0]     rem_reg   [0:TB-1];
    logic [DW-1:0]     den_reg   [0:TB-1];
    logic [TB-1:0]     quo_reg   [0:TB-1];

    logic              valid_st  [0:TB];
    logic              hit_st    [0:TB];
    logic [NW-1:0]     rem_st    [0:TB];
    logic [DW-1:0]     den_st    [0:TB];
    logic [TB-1:0]     quo_st    [0:TB];

    assign valid_st[0] = in_valid;
    assign hit_st[0]   = in_hit;
    assign rem_st[0]   = num;
    assign den_st[0]   = den;
    assign quo_st[0]   = '0;

    for (genvar j = 0; j < TB; j++)
    begin : g_stage
        logic [CW-1:0] rem_w;
        logic [CW-1:0] sub_w;
        logic          ge;

        // Compare the remainder against the divisor weighted by this bit
        assign rem_w = CW'(rem_st[j]);
        assign sub_w = CW'(den_st[j]) << (TB - 1 - j);
        assign ge    = (rem_w >= sub_w);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_st[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hit_reg[j] <= hit_st[j];
                rem_reg[j] <= ge ? NW'(rem_w - sub_w) : rem_st[j];
                den_reg[j] <= den_st[j];
                quo_reg[j] <= {quo_st[j][TB-2:0], ge};
            end
        end

        assign valid_st[j+1] = valid_reg[j];
        assign hit_st[j+1]   = hit_reg[j];
        assign rem_st[j+1]   = rem_reg[j];
        assign den_st[j+1]   = den_reg[j];
        assign quo_st[j+1]   = quo_reg[j];
    end

    assign out_valid = valid_st[TB];
    assign out_hit   = hit_st[TB];
    assign quo       = quo_st[TB];

endmodule

FILE: rtl/core/sphere_pair_collision_time.sv
// Top level of the sphere pair collision time pipeline.
// Depends on spc_pkg, spc_wmul, spc_sqrt and spc_div.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | two moving spheres and a time window
//  m_*     | out | m_tvalid/m_tready  | hit flag and contact time
//
// One pair enters every cycle unless m_tready stalls the output; the square
// root has RB stages (55 at AXIS_BITS = 21), and both the root and the
// divider resolve one bit per stage.
// Reset clears only the valid bits; payload registers carry no reset.
// A stall on m_tready freezes every stage at once, so nothing is lost or
// repeated; s_tready stays high while the output stage is empty or taken.
module sphere_pair_collision_time #(
    parameter int AXIS_BITS = 21
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_a[62:0], vel_a[125:63], radius_a[146:126], pos_b[209:147],
    // vel_b[272:210], radius_b[293:273], window[314:294], zeros above
    input  logic [spc_pkg::S_DATA_BITS-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit[0], contact_time[21:1], zeros above
    output logic [spc_pkg::M_DATA_BITS-1:0]    m_tdata
);

    localparam int FB   = spc_pkg::FIELD_BITS;
    localparam int RAB  = spc_pkg::RADIUS_BITS;
    localparam int TB   = spc_pkg::TIME_BITS;
    localparam int FRAC = spc_pkg::FRAC_BITS;
    localparam int SW   = spc_pkg::SUM_BITS;
    localparam int MDW  = spc_pkg::M_DATA_BITS;

    // Field offsets in s_tdata
    localparam int OFF_PA = 0;
    localparam int OFF_VA = OFF_PA + FB;
    localparam int OFF_RA = OFF_VA + FB;
    localparam int OFF_PB = OFF_RA + RAB;
    localparam int OFF_VB = OFF_PB + FB;
    localparam int OFF_RB = OFF_VB + FB;
    localparam int OFF_WN = OFF_RB + RAB;

    localparam int DW  = AXIS_BITS + 1;                   // axis difference
    localparam int PW  = 2 * DW;                          // axis product
    localparam int DSW = PW + 2;                          // signed dot sum
    localparam int M   = (PW > 2 * SW) ? PW : 2 * SW;     // magnitudes
    localparam int EW  = 2 * M + 1;                       // discriminant
    localparam int RW  = ((EW + 2 * FRAC + 1) / 2) * 2;   // radicand
    localparam int RB  = RW / 2;                          // root
    localparam int NW  = ((M + FRAC > RB) ? M + FRAC : RB) + 1;
    localparam int SBW = 4 * M + 2;

    logic adv;

    // Whole pipeline moves when the output stage is empty or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: differences and radius sum
    logic signed [DW-1:0] dr_reg [0:2];
    logic signed [DW-1:0] dv_reg [0:2];
    logic [SW-1:0]        s_reg;
    logic [TB-1:0]        win1_reg;
    logic                 v1_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic signed [AXIS_BITS-1:0] pa, pb, va, vb;

        assign pa = s_tdata[OFF_PA + i*AXIS_BITS +: AXIS_BITS];
        assign pb = s_tdata[OFF_PB + i*AXIS_BITS +: AXIS_BITS];
        assign va = s_tdata[OFF_VA + i*AXIS_BITS +: AXIS_BITS];
        assign vb = s_tdata[OFF_VB + i*AXIS_BITS +: AXIS_BITS];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[i] <= DW'(pa) - DW'(pb);
                dv_reg[i] <= DW'(va) - DW'(vb);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg    <= SW'(s_tdata[OFF_RA +: RAB]) + SW'(s_tdata[OFF_RB +: RAB]);
            win1_reg <= s_tdata[OFF_WN +: TB];
        end
    end

    // ---------------- stage 2: per-axis products
    logic signed [PW-1:0] dvdr_p_reg [0:2];
    logic [PW-1:0]        dr2_p_reg  [0:2];
    logic [PW-1:0]        dv2_p_reg  [0:2];
    logic [SW-1:0]        s2_reg;
    logic [TB-1:0]        win2_reg;
    logic                 v2_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dvdr_p_reg[i] <= PW'(dv_reg[i]) * PW'(dr_reg[i]);
                dr2_p_reg[i]  <= PW'(dr_reg[i]) * PW'(dr_reg[i]);
                dv2_p_reg[i]  <= PW'(dv_reg[i]) * PW'(dv_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg   <= s_reg;
            win2_reg <= win1_reg;
        end
    end

    // ---------------- stage 3: sums and squared radius sum
    logic signed [DSW-1:0] dvdr_reg;
    logic [M-1:0]          dr2_reg;
    logic [M-1:0]          dv2_reg;
    logic [M-1:0]          ss_reg;
    logic [TB-1:0]         win3_reg;
    logic                  v3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvdr_reg <= DSW'(dvdr_p_reg[0]) + DSW'(dvdr_p_reg[1]) + DSW'(dvdr_p_reg[2]);
            dr2_reg  <= M'(dr2_p_reg[0]) + M'(dr2_p_reg[1]) + M'(dr2_p_reg[2]);
            dv2_reg  <= M'(dv2_p_reg[0]) + M'(dv2_p_reg[1]) + M'(dv2_p_reg[2]);
            ss_reg   <= M'(s2_reg) * M'(s2_reg);
            win3_reg <= win2_reg;
        end
    end

    // ---------------- stage 4: reject test, P and |dr2 - S^2|
    logic          rej4_reg;
    logic          plus4_reg;
    logic [M-1:0]  p4_reg;
    logic [M-1:0]  diff4_reg;
    logic [M-1:0]  dv24_reg;
    logic [M-1:0]  win4_reg;
    logic          v4_reg;
    logic          plus4_next;

    assign plus4_next = (dr2_reg < ss_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rej4_reg  <= !dvdr_reg[DSW-1] || (dv2_reg == '0);
            plus4_reg <= plus4_next;
            p4_reg    <= M'(-dvdr_reg);
            diff4_reg <= plus4_next ? (ss_reg - dr2_reg) : (dr2_reg - ss_reg);
            dv24_reg  <= dv2_reg;
            win4_reg  <= M'(win3_reg);
        end
    end

    // ---------------- stages 5-6: wide products
    logic [2*M-1:0] pp;
    logic [2*M-1:0] ad;
    logic [2*M-1:0] wd;

    spc_wmul #(.W(M)) u_mul_pp (.clk(clk), .en(adv), .a(p4_reg),    .b(p4_reg),   .p(pp));
    spc_wmul #(.W(M)) u_mul_ad (.clk(clk), .en(adv), .a(diff4_reg), .b(dv24_reg), .p(ad));
    spc_wmul #(.W(M)) u_mul_wd (.clk(clk), .en(adv), .a(win4_reg),  .b(dv24_reg), .p(wd));

    logic          rej5_reg, rej6_reg;
    logic          plus5_reg, plus6_reg;
    logic [M-1:0]  p5_reg, p6_reg;
    logic [M-1:0]  dv25_reg, dv26_reg;
    logic          v5_reg, v6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rej5_reg  <= rej4_reg;
            plus5_reg <= plus4_reg;
            p5_reg    <= p4_reg;
            dv25_reg  <= dv24_reg;
            rej6_reg  <= rej5_reg;
            plus6_reg <= plus5_reg;
            p6_reg    <= p5_reg;
            dv26_reg  <= dv25_reg;
        end
    end

    // ---------------- stage 7: discriminant and miss test
    logic [EW-1:0]   e7_reg;
    logic            rej7_reg;
    logic            plus7_reg;
    logic [M-1:0]    p7_reg;
    logic [2*M-1:0]  wd7_reg;
    logic [M-1:0]    dv27_reg;
    logic            v7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e7_reg    <= plus6_reg ? (EW'(pp) + EW'(ad)) : (EW'(pp) - EW'(ad));
            rej7_reg  <= rej6_reg || (!plus6_reg && (ad > pp));
            plus7_reg <= plus6_reg;
            p7_reg    <= p6_reg;
            wd7_reg   <= wd;
            dv27_reg  <= dv26_reg;
        end
    end

    // ---------------- square root of E scaled by 2^20
    logic            sq_valid;
    logic [RB-1:0]   root;
    logic [SBW-1:0]  sq_sb;
    logic [RW-1:0]   rad;

    assign rad = RW'(e7_reg) << (2 * FRAC);

    spc_sqrt #(.RW(RW), .SBW(SBW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .rad       (rad),
        .sb_in     ({rej7_reg, plus7_reg, p7_reg, wd7_reg, dv27_reg}),
        .out_valid (sq_valid),
        .root      (root),
        .sb_out    (sq_sb)
    );

    logic            sq_rej;
    logic            sq_plus;
    logic [M-1:0]    sq_p;
    logic [2*M-1:0]  sq_wd;
    logic [M-1:0]    sq_dv2;

    assign {sq_rej, sq_plus, sq_p, sq_wd, sq_dv2} = sq_sb;

    // ---------------- stage 8: time numerator and window test
    logic [NW-1:0]  base;
    logic [NW-1:0]  s10;
    logic [NW-1:0]  num_next;
    logic [NW-1:0]  num8_reg;
    logic           hit8_reg;
    logic [M-1:0]   dv28_reg;
    logic           v8_reg;

    assign base = NW'(sq_p) << FRAC;
    assign s10  = NW'(root);

    always_comb
    begin
        if (sq_plus)
            num_next = base + s10;
        else if (s10 > base)
            num_next = '0;
        else
            num_next = base - s10;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num8_reg <= num_next;
            hit8_reg <= !sq_rej && ((2*M)'(num_next) <= sq_wd);
            dv28_reg <= sq_dv2;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= sq_valid;
        end
    end

    // ---------------- quotient: time = num / |dv|^2, last stage is the output
    logic           d_valid;
    logic           d_hit;
    logic [TB-1:0]  d_quo;

    spc_div #(.NW(NW), .DW(M)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v8_reg),
        .in_hit    (hit8_reg),
        .num       (num8_reg),
        .den       (dv28_reg),
        .out_valid (d_valid),
        .out_hit   (d_hit),
        .quo       (d_quo)
    );

    // Drop the quotient of a miss: report zero time
    assign m_tvalid = d_valid;
    assign m_tdata  = MDW'({(d_hit ? d_quo : {TB{1'b0}}), d_hit});

endmodule
